>>> hdl/lztd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ token decompressor package
// Token codes and the stage record passed from the sequencer to the output.
// ----------------------------------------------------------------------------
package lztd_pkg;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_LIT   = 2'd1;
  localparam logic [1:0] MODE_MATCH = 2'd2;

  localparam int POS_W = 20;
  localparam int LEN_W = 4;
  localparam int OFF_W = 16;
  localparam int FSZ_W = 21;

  // One slot of the write stage. A slot with byte_en carries one output byte;
  // tok_end marks the slot that closes a token (with or without a byte).
  typedef struct packed {
    logic             byte_en;
    logic             tok_end;
    logic             lit_sel;
    logic [7:0]       lit;
    logic [POS_W-1:0] pos;
  } lztd_stage_t;

endpackage

>>> hdl/lztd_history_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ history RAM
// Single-clock history memory with one write and one registered read port.
// A read that hits the address written in the same cycle returns new data.
// ----------------------------------------------------------------------------
module lztd_history_ram #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int AW            = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [HISTORY_DEPTH];
  logic [7:0] q_r;
  logic [7:0] fwd_data_r;
  logic       fwd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r      <= 1'b0;
      fwd_data_r <= 8'd0;
    end else if (re) begin
      fwd_r      <= we && (raddr == waddr);
      fwd_data_r <= wdata;
    end
  end

  assign rdata = fwd_r ? fwd_data_r : q_r;

  a_fwd_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (re && we && (raddr == waddr)) |=> (rdata == $past(wdata)))
    else $error("read-during-write to the same entry did not return new data");

endmodule

>>> hdl/lztd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ token sequencer
// Accepts tokens, keeps the write count and frame limit, and walks a match one
// element per unstalled cycle, issuing history reads, filling the write stage.
// ----------------------------------------------------------------------------
module lztd_seq
  import lztd_pkg::*;
#(
  parameter int HISTORY_DEPTH   = 65536,
  parameter int MAX_FRAME_BYTES = 1048576,
  parameter int MAX_MATCH       = 15,
  parameter int AW              = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              tok_valid,
  output logic              tok_ready,
  input  logic [1:0]        tok_mode,
  input  logic [7:0]        tok_lit,
  input  logic [OFF_W-1:0]  tok_offset,
  input  logic [LEN_W-1:0]  tok_length,
  input  logic [FSZ_W-1:0]  tok_fsize,
  output logic              re,
  output logic [AW-1:0]     raddr,
  output lztd_stage_t       stage,
  output logic [AW-1:0]     stage_waddr
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW = (CW > FSZ_W) ? CW : FSZ_W;
  localparam int XW = ((CW > OFF_W) ? CW : OFF_W) + 1;
  localparam int QB = 17 - $clog2(HISTORY_DEPTH);
  localparam logic [CW-1:0] MAXC = CW'(MAX_FRAME_BYTES);
  localparam logic [AW-1:0] ALAST = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN} state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    wc_r, wc_nxt;
  logic [FSZ_W-1:0] limit_r, limit_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  logic [CW-1:0]    start_r, start_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [AW-1:0]    omod_r, omod_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  lztd_stage_t      stage_r, stage_nxt;
  logic [AW-1:0]    swa_r, swa_nxt;

  logic [XW-1:0]    at_x;
  logic [XW-1:0]    src_x;
  logic             emit;
  logic             below_limit;
  logic             room;

  // Offset reduced modulo the history depth by restoring compare-subtract.
  function automatic logic [AW-1:0] off_mod(input logic [OFF_W-1:0] v);
    logic [23:0] r;
    r = 24'(v);
    for (int b = QB - 1; b >= 0; b--) begin
      if (r >= (24'(HISTORY_DEPTH) << b)) begin
        r = r - (24'(HISTORY_DEPTH) << b);
      end
    end
    return AW'(r);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == ALAST) ? '0 : AW'(p + 1'b1);
  endfunction

  assign below_limit = LW'(wc_r) < LW'(limit_r);
  assign room        = wc_r < MAXC;
  assign at_x        = XW'(start_r) + XW'(i_r);
  assign src_x       = at_x - XW'(off_r);
  assign emit        = (at_x >= XW'(off_r)) && (src_x < XW'(wc_r)) && room;

  assign tok_ready   = (state_r == ST_IDLE) && adv;
  assign re          = adv && (state_r == ST_RUN) && emit;
  assign raddr       = rp_r;
  assign stage       = stage_r;
  assign stage_waddr = swa_r;

  always_comb begin
    state_nxt = state_r;
    wc_nxt    = wc_r;
    limit_nxt = limit_r;
    wa_nxt    = wa_r;
    start_nxt = start_r;
    i_nxt     = i_r;
    len_nxt   = len_r;
    off_nxt   = off_r;
    omod_nxt  = omod_r;
    rp_nxt    = rp_r;
    stage_nxt = '0;
    swa_nxt   = wa_r;
    case (state_r)
      ST_IDLE: begin
        if (tok_valid) begin
          case (tok_mode)
            MODE_START: begin
              limit_nxt = tok_fsize;
              wc_nxt    = '0;
              wa_nxt    = '0;
            end
            MODE_LIT: begin
              if (below_limit && room) begin
                stage_nxt.byte_en = 1'b1;
                stage_nxt.tok_end = 1'b1;
                stage_nxt.lit_sel = 1'b1;
                stage_nxt.lit     = tok_lit;
                stage_nxt.pos     = POS_W'(wc_r);
                wc_nxt            = CW'(wc_r + 1'b1);
                wa_nxt            = ptr_inc(wa_r);
              end
            end
            MODE_MATCH: begin
              if (below_limit && (tok_length != '0)) begin
                start_nxt = wc_r;
                i_nxt     = '0;
                len_nxt   = (tok_length > LEN_W'(MAX_MATCH)) ? LEN_W'(MAX_MATCH) : tok_length;
                off_nxt   = tok_offset;
                omod_nxt  = off_mod(tok_offset);
                state_nxt = ST_SETUP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SETUP: begin
        // Source pointer of element 0: (start - offset) modulo the depth.
        if (wa_r >= omod_r) begin
          rp_nxt = AW'(wa_r - omod_r);
        end else begin
          rp_nxt = AW'((AW+1)'(wa_r) + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(omod_r));
        end
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        stage_nxt.tok_end = (i_r == LEN_W'(len_r - 1'b1));
        if (emit) begin
          stage_nxt.byte_en = 1'b1;
          stage_nxt.pos     = POS_W'(wc_r);
          wc_nxt            = CW'(wc_r + 1'b1);
          wa_nxt            = ptr_inc(wa_r);
        end
        rp_nxt = ptr_inc(rp_r);
        i_nxt  = LEN_W'(i_r + 1'b1);
        if (stage_nxt.tok_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wc_r    <= '0;
      limit_r <= '0;
      wa_r    <= '0;
      start_r <= '0;
      i_r     <= '0;
      len_r   <= '0;
      off_r   <= '0;
      omod_r  <= '0;
      rp_r    <= '0;
      stage_r <= '0;
      swa_r   <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
      wc_r    <= wc_nxt;
      limit_r <= limit_nxt;
      wa_r    <= wa_nxt;
      start_r <= start_nxt;
      i_r     <= i_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
      omod_r  <= omod_nxt;
      rp_r    <= rp_nxt;
      stage_r <= stage_nxt;
      swa_r   <= swa_nxt;
    end
  end

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (i_r < len_r))
    else $error("match element index ran past the match length");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= MAXC)
    else $error("write count passed the frame maximum");

  a_byte_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && re) |=> stage_r.byte_en && !stage_r.lit_sel)
    else $error("history read issued without a matching write slot");

endmodule

>>> hdl/lztd_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ output stage
// Writes each byte back to history, holds the newest byte until it is known
// whether it closes its token, and drives the output register.
// ----------------------------------------------------------------------------
module lztd_out
  import lztd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lztd_stage_t      stage,
  input  logic [7:0]       rdata,
  output logic             adv,
  output logic             we,
  output logic [7:0]       wdata,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [POS_W-1:0] out_pos,
  output logic             out_last
);

  logic             p_valid_r, p_valid_nxt;
  logic             p_final_r, p_final_nxt;
  logic [7:0]       p_data_r, p_data_nxt;
  logic [POS_W-1:0] p_pos_r, p_pos_nxt;
  logic             o_valid_r, o_valid_nxt;
  logic [7:0]       o_data_r, o_data_nxt;
  logic [POS_W-1:0] o_pos_r, o_pos_nxt;
  logic             o_last_r, o_last_nxt;
  logic             o_free;
  logic             final_now;

  assign o_free = !o_valid_r || out_ready;
  assign adv    = !p_valid_r || o_free;
  assign wdata  = stage.lit_sel ? stage.lit : rdata;
  assign we     = adv && stage.byte_en;

  always_comb begin
    p_valid_nxt = p_valid_r;
    p_final_nxt = p_final_r;
    p_data_nxt  = p_data_r;
    p_pos_nxt   = p_pos_r;
    o_valid_nxt = o_valid_r && !out_ready;
    o_data_nxt  = o_data_r;
    o_pos_nxt   = o_pos_r;
    o_last_nxt  = o_last_r;
    final_now   = p_final_r || (adv && stage.tok_end && !stage.byte_en);
    if (we) begin
      // A new byte pushes the held one out; the held one is final only if
      // its own token had already closed.
      if (p_valid_r) begin
        o_valid_nxt = 1'b1;
        o_data_nxt  = p_data_r;
        o_pos_nxt   = p_pos_r;
        o_last_nxt  = p_final_r;
      end
      p_valid_nxt = 1'b1;
      p_final_nxt = stage.tok_end;
      p_data_nxt  = wdata;
      p_pos_nxt   = stage.pos;
    end else if (p_valid_r && final_now && o_free) begin
      o_valid_nxt = 1'b1;
      o_data_nxt  = p_data_r;
      o_pos_nxt   = p_pos_r;
      o_last_nxt  = 1'b1;
      p_valid_nxt = 1'b0;
      p_final_nxt = 1'b0;
    end else if (p_valid_r && final_now) begin
      p_final_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      p_final_r <= 1'b0;
      p_data_r  <= '0;
      p_pos_r   <= '0;
      o_valid_r <= 1'b0;
      o_data_r  <= '0;
      o_pos_r   <= '0;
      o_last_r  <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      p_final_r <= p_final_nxt;
      p_data_r  <= p_data_nxt;
      p_pos_r   <= p_pos_nxt;
      o_valid_r <= o_valid_nxt;
      o_data_r  <= o_data_nxt;
      o_pos_r   <= o_pos_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_byte  = o_data_r;
  assign out_pos   = o_pos_r;
  assign out_last  = o_last_r;

  a_final_held: assert property (@(posedge clk) disable iff (!rst_n)
    p_final_r |-> p_valid_r)
    else $error("final mark set on an empty hold register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && we) |=> o_valid_r)
    else $error("held byte was replaced without being sent");

endmodule

>>> hdl/lz_token_decompressor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ token decompressor
// Rebuilds a frame's byte stream from parsed literal and match tokens.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one token per transaction: in_tuser holds the
//   token kind (frame start, literal, match) and in_tdata the literal byte,
//   back offset, match length and frame size. The out_ channel returns one
//   decompressed byte per transaction with its frame position; out_tlast
//   marks the final byte that a token produced. Tokens that produce nothing
//   (frame start, tokens past the frame limit, matches whose elements all
//   fall outside the window) return no transaction.
//   A literal or frame start leaves the unit ready for the next token; a match
//   holds the input through a setup step that reduces the offset into the
//   history ring, then one history read-modify-write per element, and no new
//   token is taken until the match ends. The single history RAM port pair
//   sets this pace; a copy that overlaps its own output is forwarded. On its
//   way to out_, a byte passes the history read, the write-back to history,
//   the hold until its token end is known and the output register.
//   Reset clears the write count, frame limit and all pipeline state; the
//   history RAM is not cleared and a frame only reads what it has written.
//   When the receiver stalls, the output register and one held byte fill,
//   then the whole pipeline freezes and in_tready stays low.
// ----------------------------------------------------------------------------
module lz_token_decompressor_unit
  import lztd_pkg::*;
#(
  parameter int HISTORY_DEPTH   = 65536,
  parameter int MAX_FRAME_BYTES = 1048576,
  parameter int MAX_MATCH       = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // literal_byte[7:0], match_offset[23:8],
                                  // match_length[27:24], frame_size[48:28], zero pad
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data_byte[7:0], position[27:8], zero pad
  output logic        out_tlast   // last
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic             adv;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;
  logic             we;
  logic [7:0]       wdata;
  logic [AW-1:0]    waddr;
  lztd_stage_t      stage;
  logic [7:0]       o_byte;
  logic [POS_W-1:0] o_pos;

  lztd_seq #(
    .HISTORY_DEPTH   (HISTORY_DEPTH),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .MAX_MATCH       (MAX_MATCH),
    .AW              (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .tok_valid   (in_tvalid),
    .tok_ready   (in_tready),
    .tok_mode    (in_tuser),
    .tok_lit     (in_tdata[7:0]),
    .tok_offset  (in_tdata[23:8]),
    .tok_length  (in_tdata[27:24]),
    .tok_fsize   (in_tdata[48:28]),
    .re          (re),
    .raddr       (raddr),
    .stage       (stage),
    .stage_waddr (waddr)
  );

  lztd_history_ram #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AW            (AW)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  lztd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .rdata     (rdata),
    .adv       (adv),
    .we        (we),
    .wdata     (wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (o_byte),
    .out_pos   (o_pos),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'd0, o_pos, o_byte};

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ token decompressor testbench
// Streams parsed LZ tokens into the unit and predicts every decompressed byte
// with a behavioral copy of the history ring and frame counters. Each output
// transaction is checked against that prediction while both stream sides
// idle and stall in several patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import lztd_pkg::*;

  localparam int HIST_DEPTH   = 65536;
  localparam int FRAME_MAX    = 1048576;
  localparam int MATCH_MAX    = 15;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AT      = 40;    // token count that starts the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_PHASES   = 4;

  // One parsed token as the generator and the predictor see it.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  lit;
    logic [15:0] off;
    logic [3:0]  len;
    logic [20:0] fsize;
  } lz_token_t;

  // One decompressed byte as it leaves the out_ channel.
  typedef struct packed {
    logic [7:0]  data;
    logic [19:0] pos;
    logic        last;
  } lz_byte_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;  // literal_byte, match_offset, match_length, frame_size, pad
  logic [1:0]  in_tuser   = '0;  // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // data_byte, position, pad
  logic        out_tlast;        // last

  lz_token_decompressor_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the history ring, the frame byte count and its limit.
  // The expected bytes queue holds every byte still owed by the unit, oldest
  // first.
  // --------------------------------------------------------------------------
  logic [7:0]  ring [0:HIST_DEPTH-1];
  logic [20:0] pred_count = '0;
  logic [20:0] frame_limit = '0;
  lz_byte_t    expected_bytes [$];

  // Stimulus side: tokens waiting for the driver, and a rough running count
  // of the frame so the generator can aim matches at data that exists.
  lz_token_t   pending_tokens [$];
  int unsigned gen_count = 0;
  int unsigned gen_limit = 0;

  lz_token_t   cur_token = '0;
  bit          in_fire = 1'b0;
  int unsigned tokens_taken = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;
  lz_byte_t    seen_byte;
  lz_byte_t    want_byte;

  // Appends one byte to the frame. The byte before it is released with last
  // cleared; the final byte of a token is released once the token is done.
  // Bytes past the largest frame size are dropped entirely.
  task automatic emit_byte(input logic [7:0] b, inout lz_byte_t pend, inout bit have_pend);
    if (32'(pred_count) < FRAME_MAX) begin
      ring[32'(pred_count) % HIST_DEPTH] = b;
      if (have_pend)
        expected_bytes.push_back(pend);
      pend.data = b;
      pend.pos  = pred_count[19:0];
      pend.last = 1'b0;
      have_pend = 1'b1;
      pred_count = pred_count + 21'd1;
    end
  endtask

  task automatic decode_token(input lz_token_t t);
    int unsigned start;
    int unsigned at;
    int unsigned src;
    int unsigned n;
    int unsigned i;
    lz_byte_t    pend;
    bit          have_pend;
    pend = '0;
    have_pend = 1'b0;
    case (t.mode)
      MODE_START: begin
        // The history survives a frame start; only the counters change.
        frame_limit = t.fsize;
        pred_count = '0;
      end
      MODE_LIT: begin
        if (pred_count < frame_limit)
          emit_byte(t.lit, pend, have_pend);
      end
      MODE_MATCH: begin
        // Only the start of a match is gated by the limit; once begun it
        // may run past it. Elements whose source lies before the frame or
        // not yet written are skipped, which also makes a zero offset empty.
        if (pred_count < frame_limit) begin
          start = 32'(pred_count);
          n = (32'(t.len) > MATCH_MAX) ? MATCH_MAX : 32'(t.len);
          for (i = 0; i < n; i++) begin
            at = start + i;
            if (32'(pred_count) < FRAME_MAX && at >= 32'(t.off)) begin
              src = at - 32'(t.off);
              if (src < 32'(pred_count))
                emit_byte(ring[src % HIST_DEPTH], pend, have_pend);
            end
          end
        end
      end
      default: begin
        // The unused mode is dropped without effect.
      end
    endcase
    if (have_pend) begin
      pend.last = 1'b1;
      expected_bytes.push_back(pend);
    end
  endtask

  task automatic log_mismatch(input string what, input lz_byte_t want, input lz_byte_t got);
    if (mismatches < MAX_REPORTS)
      $display("%s: expected byte %02h pos %0d last %0b, got byte %02h pos %0d last %0b",
               what, want.data, want.pos, want.last, got.data, got.pos, got.last);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation. Fields a token does not use are filled with random
  // values so that the unit is seen to ignore them.
  // --------------------------------------------------------------------------
  task automatic queue_token(input logic [1:0] mode, input logic [7:0] lit,
                             input logic [15:0] off, input logic [3:0] len,
                             input logic [20:0] fsize);
    lz_token_t   t;
    int unsigned base;
    int unsigned i;
    t.mode  = mode;
    t.lit   = lit;
    t.off   = off;
    t.len   = len;
    t.fsize = fsize;
    pending_tokens.push_back(t);
    if (mode == MODE_START) begin
      gen_limit = 32'(fsize);
      gen_count = 0;
    end else if (mode == MODE_LIT && gen_count < gen_limit) begin
      gen_count++;
    end else if (mode == MODE_MATCH && gen_count < gen_limit) begin
      base = gen_count;
      for (i = 0; i < 32'(len); i++)
        if (base + i >= 32'(off) && base + i - 32'(off) < gen_count)
          gen_count++;
    end
  endtask

  // Short directed sequence: empty frame, a frame cut short by its limit,
  // zero, self-overlapping and partly out-of-window matches, the unused mode,
  // and the field extremes.
  task automatic queue_directed();
    queue_token(MODE_START, 8'hFF, 16'hFFFF, 4'hF, 21'd0);
    queue_token(MODE_LIT,   8'h00, 16'h0000, 4'h0, 21'd0);
    queue_token(MODE_MATCH, 8'h00, 16'd1,    4'd15, 21'd0);
    queue_token(MODE_START, 8'h00, 16'h0000, 4'h0, 21'd20);
    queue_token(MODE_LIT,   8'h00, 16'h0000, 4'h0, 21'd0);
    queue_token(MODE_LIT,   8'hFF, 16'hFFFF, 4'hF, 21'(FRAME_MAX));
    queue_token(MODE_MATCH, 8'h00, 16'd0,    4'd5, 21'd0);
    queue_token(MODE_MATCH, 8'h00, 16'd1,    4'd15, 21'd0);
    queue_token(MODE_LIT,   8'hA5, 16'h0000, 4'h0, 21'd0);
    // Starts below the limit of 20 and runs well past it.
    queue_token(MODE_MATCH, 8'h00, 16'd3,    4'd15, 21'd0);
    queue_token(MODE_LIT,   8'h3C, 16'h0000, 4'h0, 21'd0);
    queue_token(MODE_MATCH, 8'h00, 16'hFFFF, 4'd15, 21'd0);
    queue_token(MODE_UNUSED, 8'hFF, 16'hFFFF, 4'hF, 21'(FRAME_MAX));
    queue_token(MODE_START, 8'h00, 16'h0000, 4'h0, 21'(FRAME_MAX));
    queue_token(MODE_LIT,   8'h5A, 16'h0000, 4'h0, 21'd0);
    queue_token(MODE_LIT,   8'hC3, 16'h0000, 4'h0, 21'd0);
    queue_token(MODE_MATCH, 8'h00, 16'd2,    4'd0, 21'd0);
    // Offset beyond the frame: the leading elements fall outside the window.
    queue_token(MODE_MATCH, 8'h00, 16'd5,    4'd15, 21'd0);
    queue_token(MODE_MATCH, 8'h00, 16'hFFFF, 4'd15, 21'd0);
    queue_token(MODE_MATCH, 8'h00, 16'd1,    4'd1, 21'd0);
  endtask

  // Mostly well-formed frames: literals and matches aimed at recent data,
  // with some frame restarts, wild offsets and unused-mode noise mixed in.
  task automatic queue_random(input int unsigned count);
    int unsigned roll;
    int unsigned sel;
    int unsigned hi;
    logic [20:0] size;
    queue_token(MODE_START, 8'($urandom), 16'($urandom), 4'($urandom),
                21'($urandom_range(16, 120)));
    repeat (count) begin
      roll = $urandom_range(99);
      if ((gen_count >= gen_limit && roll < 50) || roll < 6) begin
        sel = $urandom_range(9);
        if (sel == 0)
          size = '0;
        else if (sel == 1)
          size = 21'(FRAME_MAX);
        else if (sel == 2)
          size = 21'($urandom_range(FRAME_MAX));
        else
          size = 21'($urandom_range(1, 120));
        queue_token(MODE_START, 8'($urandom), 16'($urandom), 4'($urandom), size);
      end else if (roll < 9) begin
        queue_token(MODE_UNUSED, 8'($urandom), 16'($urandom), 4'($urandom),
                    21'($urandom_range(FRAME_MAX)));
      end else if (roll < 40) begin
        queue_token(MODE_LIT, 8'($urandom), 16'($urandom), 4'($urandom), 21'($urandom));
      end else if (roll < 50) begin
        queue_token(MODE_MATCH, 8'($urandom), 16'($urandom), 4'($urandom), 21'($urandom));
      end else begin
        hi = (gen_count == 0) ? 1 : ((gen_count < 40) ? gen_count : 40);
        queue_token(MODE_MATCH, 8'($urandom), 16'($urandom_range(1, hi)),
                    4'($urandom_range(MATCH_MAX)), 21'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the next pending token at the falling edge whenever the
  // channel is free, unless the current phase decides to idle this cycle.
  // A presented token stays put until its transaction completes.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_tokens.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_token = pending_tokens.pop_front();
        in_tdata  <= {7'd0, cur_token.fsize, cur_token.len, cur_token.off, cur_token.lit};
        in_tuser  <= cur_token.mode;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per phase, plus one long hold-off early in the
  // run while the sender keeps offering tokens, so that the unit fills up
  // and has to drop in_tready.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && tokens_taken == HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: at each rising edge, feed an accepted token to the predictor
  // first, then check an accepted output byte against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_tvalid && in_tready;
      if (in_fire) begin
        decode_token(cur_token);
        tokens_taken++;
      end
      if (out_tvalid && out_tready) begin
        seen_byte.data = out_tdata[7:0];
        seen_byte.pos  = out_tdata[27:8];
        seen_byte.last = out_tlast;
        if (expected_bytes.size() == 0) begin
          log_mismatch("unexpected output", '0, seen_byte);
        end else begin
          want_byte = expected_bytes.pop_front();
          if (seen_byte.data != want_byte.data || seen_byte.pos != want_byte.pos ||
              seen_byte.last != want_byte.last)
            log_mismatch("output mismatch", want_byte, seen_byte);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lz_token_decompressor_unit test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Run sequence: reset, then four traffic phases (free flowing, sender
  // mostly idle, receiver mostly stalled, both occasionally idle). Each phase
  // drains completely before the next one starts.
  // --------------------------------------------------------------------------
  int unsigned phase_idle   [NUM_PHASES] = '{0, 80, 0, 17};
  int unsigned phase_stall  [NUM_PHASES] = '{0, 0, 80, 17};
  int unsigned phase_tokens [NUM_PHASES] = '{40, 50, 50, 50};

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = phase_idle[p];
      stall_pct     = phase_stall[p];
      if (p == 0) begin
        queue_directed();
      end
      queue_random(phase_tokens[p]);
      while (pending_tokens.size() != 0 || in_tvalid || expected_bytes.size() != 0)
        @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0d expected bytes never arrived", expected_bytes.size());
      mismatches += expected_bytes.size();
    end
    if (mismatches == 0)
      $display("lz_token_decompressor_unit test passed");
    else
      $display("lz_token_decompressor_unit test failed");
    $finish;
  end

endmodule
